// ===== rtl/dsre_pkg.sv =====
// Shared constants, result type and CRC-16 helpers for the disk sector record encoder.
// Depends on nothing; imported by every module of the encoder.
`timescale 1ns / 1ps

package dsre_pkg;

   localparam int BYTE_W        = 8;
   localparam int SECTOR_BYTES  = 256;
   localparam int HDR_BYTES     = 4;
   // Header, one data byte and two CRC bytes, which is the case of a one-byte sector
   localparam int MAX_BEATS     = HDR_BYTES + 3;
   localparam int CNT_W         = $clog2(MAX_BEATS + 1);
   localparam int REQ_DATA_W    = 24;

   localparam logic [BYTE_W-1:0] DATA_XOR    = 8'hB3;
   localparam logic [BYTE_W-1:0] FORMAT_BYTE = 8'h00;
   localparam logic [BYTE_W-1:0] PROT_BYTE   = 8'h00;
   localparam logic [15:0]       CRC_SEED    = 16'hFFFF;

   // Beats of one accepted item, lowest index goes out first
   typedef struct packed {
      logic                            valid;
      logic [MAX_BEATS-1:0][BYTE_W-1:0] beats;
      logic [CNT_W-1:0]                count;
      logic                            ends;
   } result_type;

   // Reflected CRC-16 (0x8408) nibble table
   function automatic logic [15:0] crc_table(input logic [3:0] idx);
      logic [15:0] val;
      case (idx)
         4'h0: val = 16'h0000;
         4'h1: val = 16'h1081;
         4'h2: val = 16'h2102;
         4'h3: val = 16'h3183;
         4'h4: val = 16'h4204;
         4'h5: val = 16'h5285;
         4'h6: val = 16'h6306;
         4'h7: val = 16'h7387;
         4'h8: val = 16'h8408;
         4'h9: val = 16'h9489;
         4'hA: val = 16'ha50a;
         4'hB: val = 16'hb58b;
         4'hC: val = 16'hc60c;
         4'hD: val = 16'hd68d;
         4'hE: val = 16'he70e;
         4'hF: val = 16'hf78f;
         default: val = 16'h0000;
      endcase
      return val;
   endfunction

   // Update the CRC with one byte, low nibble first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = {4'h0, crc[15:4]} ^ crc_table(crc[3:0] ^ b[3:0]);
      c = {4'h0, c[15:4]} ^ crc_table(c[3:0] ^ b[7:4]);
      return c;
   endfunction

   // CRC after the seed and the two constant header bytes
   localparam logic [15:0] HDR_CRC = crc_byte(crc_byte(CRC_SEED, FORMAT_BYTE), PROT_BYTE);

endpackage

// ===== rtl/dsre_frame.sv =====
// Input register, sector position and running CRC; builds the beats of one item.
// Depends on dsre_pkg.
`timescale 1ns / 1ps

module dsre_frame #(
   parameter int SECTOR_BYTES = dsre_pkg::SECTOR_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [dsre_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tuser,
   input  logic                             buf_free,
   output dsre_pkg::result_type             load
);
   import dsre_pkg::*;

   localparam int POS_W = (SECTOR_BYTES > 1) ? $clog2(SECTOR_BYTES) : 1;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] data_ff, track_ff, sector_ff;
   logic              fill_ff;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [15:0]       crc_ff, crc_in;

   logic              req_take, commit, first, last;
   logic [BYTE_W-1:0] value, enc;
   logic [15:0]       crc_start;

   // Hand the held beat on when the output buffer frees up
   assign commit     = in_valid_ff && buf_free;
   assign req_tready = !in_valid_ff || commit;
   assign req_take   = req_tvalid && req_tready;

   assign first = (pos_ff == '0);
   assign last  = (pos_ff == POS_W'(SECTOR_BYTES - 1));
   assign value = fill_ff ? '0 : data_ff;
   assign enc   = value ^ DATA_XOR;

   // Reseed through the header at sector start, then fold in the data byte
   always_comb begin
      if (first) begin
         crc_start = crc_byte(crc_byte(HDR_CRC, track_ff), sector_ff);
      end else begin
         crc_start = crc_ff;
      end
      crc_in = crc_byte(crc_start, value);
   end

   // Assemble the beats for this item
   always_comb begin
      load       = '0;
      load.valid = commit;
      load.ends  = last;
      if (first && last) begin
         load.beats[0] = FORMAT_BYTE;
         load.beats[1] = PROT_BYTE;
         load.beats[2] = track_ff;
         load.beats[3] = sector_ff;
         load.beats[4] = enc;
         load.beats[5] = crc_in[15:8];
         load.beats[6] = crc_in[7:0];
         load.count    = CNT_W'(HDR_BYTES + 3);
      end else if (first) begin
         load.beats[0] = FORMAT_BYTE;
         load.beats[1] = PROT_BYTE;
         load.beats[2] = track_ff;
         load.beats[3] = sector_ff;
         load.beats[4] = enc;
         load.count    = CNT_W'(HDR_BYTES + 1);
      end else if (last) begin
         load.beats[0] = enc;
         load.beats[1] = crc_in[15:8];
         load.beats[2] = crc_in[7:0];
         load.count    = CNT_W'(3);
      end else begin
         load.beats[0] = enc;
         load.count    = CNT_W'(1);
      end
   end

   // Next input valid and position
   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (commit) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (commit) begin
         pos_in = last ? '0 : pos_ff + POS_W'(1);
      end else begin
         pos_in = pos_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pos_ff      <= '0;
         crc_ff      <= CRC_SEED;
      end else begin
         in_valid_ff <= in_valid_in;
         pos_ff      <= pos_in;
         if (commit) begin
            crc_ff <= crc_in;
         end
      end
   end

   // Capture the input beat
   always_ff @(posedge clock) begin
      if (req_take) begin
         data_ff   <= req_tdata[7:0];
         track_ff  <= req_tdata[15:8];
         sector_ff <= req_tdata[23:16];
         fill_ff   <= req_tuser;
      end
   end

endmodule

// ===== rtl/dsre_out_buf.sv =====
// Output shift buffer: holds one item's beats, sends one per rsp_tready cycle.
// Depends on dsre_pkg.
`timescale 1ns / 1ps

module dsre_out_buf (
   input  logic                        clock,
   input  logic                        reset,
   input  dsre_pkg::result_type        load,
   output logic                        buf_free,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [dsre_pkg::BYTE_W-1:0] rsp_tdata,
   output logic                        rsp_tlast
);
   import dsre_pkg::*;

   logic [MAX_BEATS-1:0][BYTE_W-1:0] beats_ff, beats_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic                             ends_ff, ends_in;
   logic                             take;

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = beats_ff[0];
   assign rsp_tlast  = ends_ff && (count_ff == CNT_W'(1));
   assign take       = rsp_tvalid && rsp_tready;
   assign buf_free   = (count_ff == '0) || ((count_ff == CNT_W'(1)) && rsp_tready);

   // Load a new item or shift out the sent beat
   always_comb begin
      beats_in = beats_ff;
      count_in = count_ff;
      ends_in  = ends_ff;
      if (load.valid) begin
         beats_in = load.beats;
         count_in = load.count;
         ends_in  = load.ends;
      end else if (take) begin
         beats_in = {{BYTE_W{1'b0}}, beats_ff[MAX_BEATS-1:1]};
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      beats_ff <= beats_in;
      ends_ff  <= ends_in;
   end

   // A load lands only on an empty buffer or one whose final beat is leaving
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load.valid |-> ((count_ff == '0) || ((count_ff == CNT_W'(1)) && take)))
      else $error("item loaded over pending beats");

   // A loaded item takes its beat count
   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load.valid |=> (count_ff == $past(load.count)))
      else $error("beat count not taken from load");

   // A sent beat without a load drops the count by one
   a_shift_count: assert property (@(posedge clock) disable iff (reset)
      (take && !load.valid) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("beat count did not advance");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BEATS))
      else $error("beat count out of range");

endmodule

// ===== rtl/disk_sector_record_encoder.sv =====
// Disk sector record encoder: takes the data bytes of one sector and sends the
// encoded record of SECTOR_BYTES + 6 bytes, one byte per result beat. The first data
// byte of a sector produces five beats (format 0, protection 0, track, sector, data),
// middle bytes one beat, and the last byte three (data, CRC high, CRC low with tlast);
// data goes out XORed with 0xB3 and the reflected CRC-16 covers header and plain data.
// The output port moves one byte per cycle while rsp_tready is high. An accepted item
// passes through the input register and then the output shift buffer before its
// first beat goes out; one further input beat is held while output is stalled.
// Depends on dsre_pkg, dsre_frame and dsre_out_buf.
`timescale 1ns / 1ps

module disk_sector_record_encoder #(
   parameter int SECTOR_BYTES = dsre_pkg::SECTOR_BYTES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // data_byte [7:0], track_number [15:8], sector_number [23:16]
   input  logic [dsre_pkg::REQ_DATA_W-1:0] req_tdata,
   // zero_fill [0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_byte [7:0]
   output logic [dsre_pkg::BYTE_W-1:0]     rsp_tdata,
   output logic                            rsp_tlast
);
   import dsre_pkg::*;

   result_type load;
   logic       buf_free;

   dsre_frame #(
      .SECTOR_BYTES(SECTOR_BYTES)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .buf_free   (buf_free),
      .load       (load)
   );

   dsre_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .buf_free   (buf_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
